// ----- rtl/core/srx_pkg.sv -----
`default_nettype none

package srx_pkg;

    localparam int ADDR_W    = 64;
    localparam int COUNT_W   = 8;
    localparam int TAG_W     = 8;
    localparam int BYTES_W   = 4;
    localparam int NUM_W     = 16;
    localparam int TRACK_W   = 6;
    localparam int RUN_LEN_W = 16;
    localparam int REC_SECT  = 32;   // sectors per record at most
    localparam int K_W       = 6;    // holds 1..REC_SECT
    localparam int MOD_BITS  = 4;    // dividend bits retired per modulo step

    // one record as formed from the current record pointer
    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [BYTES_W-1:0] addr_bytes;
        logic [ADDR_W-1:0]  next_addr;
        logic               last_rec;
    } t_rec;

    // modulo unit status
    typedef struct packed {
        logic               done;
        logic [TRACK_W-1:0] rem;
    } t_mod_status;

endpackage

`default_nettype wire

// ----- rtl/core/srx_in_if.sv -----
`default_nettype none

interface srx_in_if;
    logic                          valid;
    logic                          ready;
    logic [srx_pkg::ADDR_W-1:0]    sector_addr;
    logic [srx_pkg::COUNT_W-1:0]   sector_count;

    modport source (output valid, output sector_addr, output sector_count, input ready);
    modport sink   (input valid, input sector_addr, input sector_count, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/srx_out_if.sv -----
`default_nettype none

interface srx_out_if;
    logic                          valid;
    logic                          ready;
    logic [srx_pkg::TAG_W-1:0]     record_tag;
    logic [srx_pkg::ADDR_W-1:0]    record_addr;
    logic [srx_pkg::BYTES_W-1:0]   addr_bytes;
    logic [srx_pkg::NUM_W-1:0]     record_number;
    logic                          last_of_flush;
    logic                          error;

    modport source (output valid, output record_tag, output record_addr, output addr_bytes,
                    output record_number, output last_of_flush, output error, input ready);
    modport sink   (input valid, input record_tag, input record_addr, input addr_bytes,
                    input record_number, input last_of_flush, input error, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/srx_cfg_if.sv -----
`default_nettype none

interface srx_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [srx_pkg::TRACK_W-1:0]   track_sectors;

    modport source (output valid, output track_sectors, input ready);
    modport sink   (input valid, input track_sectors, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/srx_mod.sv -----
`default_nettype none

// iterative remainder of a 64-bit address by a 6-bit track size
module srx_mod (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [srx_pkg::ADDR_W-1:0]    i_dividend,
    input  logic [srx_pkg::TRACK_W-1:0]   i_divisor,
    output srx_pkg::t_mod_status          o_status
);

    localparam int STEPS = srx_pkg::ADDR_W / srx_pkg::MOD_BITS;
    localparam int CNT_W = $clog2(STEPS);

    logic                          r_busy;
    logic                          r_done;
    logic [CNT_W-1:0]              r_cnt;
    logic [srx_pkg::ADDR_W-1:0]    r_shift;
    logic [srx_pkg::TRACK_W-1:0]   r_rem;
    logic [srx_pkg::TRACK_W-1:0]   r_div;
    logic [srx_pkg::TRACK_W-1:0]   n_rem;
    logic [srx_pkg::TRACK_W:0]     v_acc;

    // restoring steps, one dividend bit each
    always_comb begin
        n_rem = r_rem;
        v_acc = '0;
        for (int i = 0; i < srx_pkg::MOD_BITS; i++) begin
            v_acc = {n_rem, r_shift[srx_pkg::ADDR_W-1-i]};
            if (v_acc >= {1'b0, r_div}) begin
                v_acc = v_acc - {1'b0, r_div};
            end
            n_rem = v_acc[srx_pkg::TRACK_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_dividend;
            r_rem   <= '0;
            r_div   <= i_divisor;
        end else if (r_busy) begin
            r_shift <= r_shift << srx_pkg::MOD_BITS;
            r_rem   <= n_rem;
        end
    end

    assign o_status.done = r_done;
    assign o_status.rem  = r_rem;

endmodule

`default_nettype wire

// ----- rtl/core/srx_rec.sv -----
`default_nettype none

// forms one record from the record pointer and the sectors left in the chunk
module srx_rec #(
    parameter int LEFT_W = 10
) (
    input  logic [srx_pkg::ADDR_W-1:0]  i_addr,
    input  logic [LEFT_W-1:0]           i_left,
    output srx_pkg::t_rec               o_rec,
    output logic [LEFT_W-1:0]           o_next_left
);

    logic [2:0]                 v_len;
    logic [srx_pkg::K_W-1:0]    v_k;
    logic [srx_pkg::K_W-1:0]    v_km1;

    always_comb begin
        v_len = '0;
        for (int i = 1; i < 8; i++) begin
            if (i_addr[8*i +: 8] != 8'h00) begin
                v_len = 3'(i);
            end
        end
        if (i_left >= LEFT_W'(srx_pkg::REC_SECT)) begin
            v_k = srx_pkg::K_W'(srx_pkg::REC_SECT);
        end else begin
            v_k = i_left[srx_pkg::K_W-1:0];
        end
        v_km1 = v_k - 1'b1;
    end

    assign o_rec.tag        = {v_len, v_km1[4:0]};
    assign o_rec.addr_bytes = {1'b0, v_len} + 4'd1;
    assign o_rec.next_addr  = i_addr + srx_pkg::ADDR_W'(v_k);
    assign o_rec.last_rec   = (i_left <= LEFT_W'(srx_pkg::REC_SECT));
    assign o_next_left      = i_left - LEFT_W'(srx_pkg::REC_SECT);

endmodule

`default_nettype wire

// ----- rtl/core/sector_run_extent_encoder_core.sv -----
`default_nettype none

// Sector run extent encoder. Each input transfer carries a sector address and a
// sector count; contiguous blocks merge into one run, and address zero or a
// non-contiguous address flushes it. A flush cuts the run at track boundaries
// (track_sectors, 0 = no cut) and emits one output transfer per record of up to
// 32 sectors, the last one marked last_of_flush. A chunk over CHUNK_LIMIT
// sectors or a flush needing over MAX_RECORDS records yields a single error
// transfer instead. Timing: an item that only extends or starts a run, or that
// flushes an empty run, is taken while the sequencer stays idle. A flush runs a
// shared sequencer over the chunks, once to count and check and, if that pass
// found records and no error, once more to emit: with track_sectors nonzero it
// first waits on the 4-bit-per-cycle modulo unit, then each pass spends one step
// per chunk, one per record and one to close the pass, and the emit pass also
// waits while the sink holds ready low. Input ready is low for the whole flush.
module sector_run_extent_encoder_core #(
    parameter int MAX_RECORDS = 64,
    parameter int CHUNK_LIMIT = 768
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    srx_cfg_if.sink         i_cfg,
    srx_in_if.sink          i_in,
    srx_out_if.source       o_out
);

    localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
    localparam int LEFT_W = $clog2(CHUNK_LIMIT + 1);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MOD   = 3'd1;
    localparam logic [2:0] S_CHUNK = 3'd2;
    localparam logic [2:0] S_REC   = 3'd3;
    localparam logic [2:0] S_ERR   = 3'd4;

    // architectural state
    logic [srx_pkg::TRACK_W-1:0]    r_track,     n_track;
    logic [srx_pkg::ADDR_W-1:0]     r_run_start, n_run_start;
    logic [srx_pkg::RUN_LEN_W-1:0]  r_run_len,   n_run_len;
    logic [srx_pkg::NUM_W-1:0]      r_counter,   n_counter;

    // flush sequencer
    logic [2:0]                     r_state,     n_state;
    logic                           r_emit,      n_emit;
    logic [srx_pkg::ADDR_W-1:0]     r_f_start,   n_f_start;
    logic [srx_pkg::RUN_LEN_W-1:0]  r_f_len,     n_f_len;
    logic [srx_pkg::TRACK_W-1:0]    r_pos,       n_pos;
    logic                           r_first,     n_first;
    logic [srx_pkg::ADDR_W-1:0]     r_c_start,   n_c_start;
    logic [srx_pkg::RUN_LEN_W-1:0]  r_c_left,    n_c_left;
    logic [srx_pkg::ADDR_W-1:0]     r_rec_addr,  n_rec_addr;
    logic [LEFT_W-1:0]              r_rec_left,  n_rec_left;
    logic [CNT_W-1:0]               r_cnt,       n_cnt;
    logic [CNT_W-1:0]               r_total,     n_total;

    // output register
    logic                           r_o_valid,   n_o_valid;
    logic [srx_pkg::TAG_W-1:0]      r_o_tag,     n_o_tag;
    logic [srx_pkg::ADDR_W-1:0]     r_o_addr,    n_o_addr;
    logic [srx_pkg::BYTES_W-1:0]    r_o_bytes,   n_o_bytes;
    logic [srx_pkg::NUM_W-1:0]      r_o_num,     n_o_num;
    logic                           r_o_last,    n_o_last;
    logic                           r_o_err,     n_o_err;

    logic [srx_pkg::ADDR_W-1:0]     w_run_end;
    logic                           w_accept;
    logic                           w_flush;
    logic                           w_out_free;
    logic                           w_mod_start;
    srx_pkg::t_mod_status           w_mod;
    logic                           w_cut;
    logic [srx_pkg::RUN_LEN_W-1:0]  w_lim;
    logic [srx_pkg::RUN_LEN_W-1:0]  w_n;
    logic                           w_chunk_err;
    srx_pkg::t_rec                  w_rec;
    logic [LEFT_W-1:0]              w_next_left;
    logic [srx_pkg::RUN_LEN_W:0]    w_sum;
    logic [srx_pkg::NUM_W-1:0]      w_counter_inc;
    logic [CNT_W-1:0]               w_cnt_inc;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);

    assign w_accept   = i_in.valid && (r_state == S_IDLE);
    assign w_run_end  = r_run_start + srx_pkg::ADDR_W'(r_run_len);
    // zero address always flushes; otherwise a live run that is not continued
    assign w_flush    = (i_in.sector_addr == '0)
                     || ((r_run_start != '0) && (i_in.sector_addr != w_run_end));
    assign w_out_free = !r_o_valid || o_out.ready;

    // track position of the run start, only needed when cutting at tracks
    assign w_mod_start = w_accept && w_flush && (r_run_len != '0) && (r_track != '0);

    srx_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (r_run_start),
        .i_divisor  (r_track),
        .o_status   (w_mod)
    );

    // next chunk size: first chunk runs to the track end unless the run starts
    // on the last sector of a track, later chunks are one track long
    assign w_cut = r_first && (r_track != '0) && (r_pos != (r_track - 1'b1));
    always_comb begin
        if (r_track == '0) begin
            w_lim = r_c_left;
        end else if (w_cut) begin
            w_lim = srx_pkg::RUN_LEN_W'(r_track - r_pos);
        end else begin
            w_lim = srx_pkg::RUN_LEN_W'(r_track);
        end
    end
    assign w_n         = (w_lim < r_c_left) ? w_lim : r_c_left;
    // a chunk starting at address zero is skipped, so it is never too long
    assign w_chunk_err = (r_c_start != '0) && (w_n > srx_pkg::RUN_LEN_W'(CHUNK_LIMIT));

    srx_rec #(
        .LEFT_W (LEFT_W)
    ) u_rec (
        .i_addr      (r_rec_addr),
        .i_left      (r_rec_left),
        .o_rec       (w_rec),
        .o_next_left (w_next_left)
    );

    assign w_counter_inc = r_counter + 1'b1;
    assign w_cnt_inc     = r_cnt + 1'b1;

    // run length grows saturating; a flush restarts it from zero
    assign w_sum = (w_flush ? '0 : {1'b0, r_run_len})
                 + (srx_pkg::RUN_LEN_W + 1)'(i_in.sector_count);

    always_comb begin
        n_track     = r_track;
        n_run_start = r_run_start;
        n_run_len   = r_run_len;
        n_counter   = r_counter;
        n_state     = r_state;
        n_emit      = r_emit;
        n_f_start   = r_f_start;
        n_f_len     = r_f_len;
        n_pos       = r_pos;
        n_first     = r_first;
        n_c_start   = r_c_start;
        n_c_left    = r_c_left;
        n_rec_addr  = r_rec_addr;
        n_rec_left  = r_rec_left;
        n_cnt       = r_cnt;
        n_total     = r_total;
        n_o_valid   = r_o_valid && !o_out.ready;
        n_o_tag     = r_o_tag;
        n_o_addr    = r_o_addr;
        n_o_bytes   = r_o_bytes;
        n_o_num     = r_o_num;
        n_o_last    = r_o_last;
        n_o_err     = r_o_err;

        if (i_cfg.valid) begin
            n_track = i_cfg.track_sectors;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    // the flush works on a snapshot, so the run can move on now
                    if (i_in.sector_addr == '0) begin
                        n_run_start = '0;
                        n_run_len   = '0;
                    end else begin
                        if (w_flush || (r_run_start == '0)) begin
                            n_run_start = i_in.sector_addr;
                        end
                        n_run_len = w_sum[srx_pkg::RUN_LEN_W] ? '1
                                  : w_sum[srx_pkg::RUN_LEN_W-1:0];
                    end
                    if (w_flush && (r_run_len != '0)) begin
                        n_f_start = r_run_start;
                        n_f_len   = r_run_len;
                        n_c_start = r_run_start;
                        n_c_left  = r_run_len;
                        n_first   = 1'b1;
                        n_cnt     = '0;
                        n_emit    = 1'b0;
                        n_state   = (r_track == '0) ? S_CHUNK : S_MOD;
                    end
                end
            end
            S_MOD: begin
                if (w_mod.done) begin
                    n_pos   = w_mod.rem;
                    n_state = S_CHUNK;
                end
            end
            S_CHUNK: begin
                if (r_c_left == '0) begin
                    if (r_emit || (r_cnt == '0)) begin
                        n_state = S_IDLE;
                    end else begin
                        // checks passed: replay the same chunks and emit
                        n_total   = r_cnt;
                        n_cnt     = '0;
                        n_emit    = 1'b1;
                        n_c_start = r_f_start;
                        n_c_left  = r_f_len;
                        n_first   = 1'b1;
                    end
                end else if (w_chunk_err) begin
                    n_state = S_ERR;
                end else begin
                    n_c_start  = r_c_start + srx_pkg::ADDR_W'(w_n);
                    n_c_left   = r_c_left - w_n;
                    n_first    = 1'b0;
                    n_rec_addr = r_c_start;
                    n_rec_left = w_n[LEFT_W-1:0];
                    if (r_c_start != '0) begin
                        n_state = S_REC;
                    end
                end
            end
            S_REC: begin
                if (!r_emit) begin
                    if (r_cnt >= CNT_W'(MAX_RECORDS)) begin
                        n_state = S_ERR;
                    end else begin
                        n_cnt      = w_cnt_inc;
                        n_rec_addr = w_rec.next_addr;
                        n_rec_left = w_next_left;
                        if (w_rec.last_rec) begin
                            n_state = S_CHUNK;
                        end
                    end
                end else if (w_out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_tag    = w_rec.tag;
                    n_o_addr   = r_rec_addr;
                    n_o_bytes  = w_rec.addr_bytes;
                    n_o_num    = w_counter_inc;
                    n_o_last   = (w_cnt_inc == r_total);
                    n_o_err    = 1'b0;
                    n_counter  = w_counter_inc;
                    n_cnt      = w_cnt_inc;
                    n_rec_addr = w_rec.next_addr;
                    n_rec_left = w_next_left;
                    if (w_rec.last_rec) begin
                        n_state = S_CHUNK;
                    end
                end
            end
            S_ERR: begin
                // run dropped, counter left as it was
                if (w_out_free) begin
                    n_o_valid = 1'b1;
                    n_o_tag   = '0;
                    n_o_addr  = '0;
                    n_o_bytes = '0;
                    n_o_num   = r_counter;
                    n_o_last  = 1'b1;
                    n_o_err   = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track     <= '0;
            r_run_start <= '0;
            r_run_len   <= '0;
            r_counter   <= '0;
            r_state     <= S_IDLE;
            r_emit      <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_track     <= n_track;
            r_run_start <= n_run_start;
            r_run_len   <= n_run_len;
            r_counter   <= n_counter;
            r_state     <= n_state;
            r_emit      <= n_emit;
            r_o_valid   <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f_start  <= n_f_start;
        r_f_len    <= n_f_len;
        r_pos      <= n_pos;
        r_first    <= n_first;
        r_c_start  <= n_c_start;
        r_c_left   <= n_c_left;
        r_rec_addr <= n_rec_addr;
        r_rec_left <= n_rec_left;
        r_cnt      <= n_cnt;
        r_total    <= n_total;
        r_o_tag    <= n_o_tag;
        r_o_addr   <= n_o_addr;
        r_o_bytes  <= n_o_bytes;
        r_o_num    <= n_o_num;
        r_o_last   <= n_o_last;
        r_o_err    <= n_o_err;
    end

    assign o_out.valid         = r_o_valid;
    assign o_out.record_tag    = r_o_tag;
    assign o_out.record_addr   = r_o_addr;
    assign o_out.addr_bytes    = r_o_bytes;
    assign o_out.record_number = r_o_num;
    assign o_out.last_of_flush = r_o_last;
    assign o_out.error         = r_o_err;

`ifndef ASSERT_OFF
    // the emit pass never goes past the record total found by the count pass
    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit |-> (r_cnt <= r_total))
        else $error("emit pass exceeded counted records");

    // an error transfer ends its flush and carries an empty record
    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_err) |-> (r_o_last && (r_o_tag == '0) && (r_o_bytes == '0)))
        else $error("malformed error transfer");

    // the modulo unit only finishes while the sequencer waits on it
    a_mod_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod.done |-> (r_state == S_MOD))
        else $error("modulo result outside its wait state");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/sector_run_extent_encoder_checker.sv -----
`timescale 1ns / 100ps

module sector_run_extent_encoder_checker #(
    parameter int MAX_RECORDS = 64,
    parameter int CHUNK_LIMIT = 768
) (
    input  logic i_clk,
    input  logic i_rst_n,
    srx_cfg_if   i_cfg_mon,
    srx_in_if    i_in_mon,
    srx_out_if   i_out_mon,
    output int   o_fail_count,
    output int   o_pending
);
    localparam int TAG_W     = srx_pkg::TAG_W;
    localparam int ADDR_W    = srx_pkg::ADDR_W;
    localparam int BYTES_W   = srx_pkg::BYTES_W;
    localparam int NUM_W     = srx_pkg::NUM_W;
    localparam int TRACK_W   = srx_pkg::TRACK_W;
    localparam int RUN_LEN_W = srx_pkg::RUN_LEN_W;
    localparam int COUNT_W   = srx_pkg::COUNT_W;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [ADDR_W-1:0]  addr;
        logic [BYTES_W-1:0] nbytes;
        logic [NUM_W-1:0]   number;
        logic               last;
        logic               err;
    } t_exp_rec;

    t_exp_rec             expected_records[$];
    t_exp_rec             flush_records[$];
    logic [TRACK_W-1:0]   track_sectors;
    logic [ADDR_W-1:0]    run_start;
    logic [RUN_LEN_W-1:0] run_length;
    logic [NUM_W-1:0]     record_count;
    logic [NUM_W-1:0]     trial_count;
    int                   fails = 0;

    // records of up to 32 sectors for one chunk, 0 once a limit is hit
    function automatic bit chunk_records(input logic [ADDR_W-1:0] start, input int unsigned n);
        logic [ADDR_W-1:0] a;
        int                left;
        int                nb;
        logic [4:0]        sect_m1;
        t_exp_rec          r;
        if (start == '0 || n == 0) return 1'b1;
        if (n > CHUNK_LIMIT) return 1'b0;
        a    = start;
        left = int'(n);
        do begin
            nb = 1;
            while (nb < 8 && (a >> (8 * nb)) != '0) nb++;
            if (flush_records.size() >= MAX_RECORDS) return 1'b0;
            trial_count = trial_count + 1'b1;
            sect_m1     = (left < 33) ? 5'(left - 1) : 5'd31;
            r.tag       = {3'(nb - 1), sect_m1};
            r.addr      = a;
            r.nbytes    = BYTES_W'(nb);
            r.number    = trial_count;
            r.last      = 1'b0;
            r.err       = 1'b0;
            flush_records.push_back(r);
            a    = a + ADDR_W'(sect_m1) + ADDR_W'(1);
            left = left - 32;
        end while (left > 0);
        return 1'b1;
    endfunction

    // cut the open run at track boundaries and queue its records
    function automatic void flush_run();
        logic [ADDR_W-1:0] s;
        int unsigned       len;
        int unsigned       t;
        int unsigned       pos;
        int unsigned       n;
        bit                ok;
        t_exp_rec          r;
        flush_records.delete();
        if (run_length == '0) return;
        s           = run_start;
        len         = run_length;
        t           = track_sectors;
        trial_count = record_count;
        ok          = 1'b1;
        if (t == 0) begin
            ok = chunk_records(s, len);
        end else begin
            pos = 32'(s % ADDR_W'(t));
            // a run starting on the last sector of a track gets no first cut
            if (pos < t - 1) begin
                n   = (t - pos > len) ? len : t - pos;
                ok  = chunk_records(s, n);
                s   = s + ADDR_W'(n);
                len = len - n;
            end
            while (ok && len > t) begin
                ok  = chunk_records(s, t);
                s   = s + ADDR_W'(t);
                len = len - t;
            end
            if (ok && len != 0) ok = chunk_records(s, len);
        end
        if (!ok) begin
            r        = '0;
            r.number = record_count;
            r.last   = 1'b1;
            r.err    = 1'b1;
            expected_records.push_back(r);
        end else begin
            record_count = trial_count;
            foreach (flush_records[i]) begin
                r      = flush_records[i];
                r.last = (i == flush_records.size() - 1);
                expected_records.push_back(r);
            end
        end
    endfunction

    function automatic void take_block(input logic [ADDR_W-1:0] a, input logic [COUNT_W-1:0] c);
        bit          do_flush;
        bit          do_cache;
        int unsigned sum;
        do_flush = 1'b0;
        do_cache = 1'b0;
        if (a == '0) begin
            do_flush = 1'b1;
        end else if (run_start == '0) begin
            do_cache = 1'b1;
        end else if (a == run_start + ADDR_W'(run_length)) begin
            do_cache = 1'b1;
        end else begin
            do_flush = 1'b1;
            do_cache = 1'b1;
        end
        if (do_flush) begin
            flush_run();
            run_start  = '0;
            run_length = '0;
        end
        if (do_cache) begin
            if (run_start == '0) run_start = a;
            sum        = run_length + c;
            run_length = (sum > 65535) ? 16'hFFFF : RUN_LEN_W'(sum);
        end
    endfunction

    function automatic void report_record(input string what, input t_exp_rec want,
                                          input t_exp_rec got);
        fails++;
        if (fails <= 10) begin
            $display("%0t %s: exp tag=%02h addr=%016h bytes=%0d num=%0d last=%0b err=%0b",
                     $realtime, what, want.tag, want.addr, want.nbytes, want.number,
                     want.last, want.err);
            $display("%0t %s: got tag=%02h addr=%016h bytes=%0d num=%0d last=%0b err=%0b",
                     $realtime, what, got.tag, got.addr, got.nbytes, got.number,
                     got.last, got.err);
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_exp_rec got;
        t_exp_rec want;
        if (!i_rst_n) begin
            expected_records.delete();
            track_sectors = '0;
            run_start     = '0;
            run_length    = '0;
            record_count  = '0;
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                got = {i_out_mon.record_tag, i_out_mon.record_addr, i_out_mon.addr_bytes,
                       i_out_mon.record_number, i_out_mon.last_of_flush, i_out_mon.error};
                if (expected_records.size() == 0) begin
                    report_record("unexpected record", '0, got);
                end else begin
                    want = expected_records.pop_front();
                    if (got.tag !== want.tag || got.addr !== want.addr ||
                        got.nbytes !== want.nbytes || got.number !== want.number ||
                        got.last !== want.last || got.err !== want.err)
                        report_record("record mismatch", want, got);
                end
            end
            if (i_cfg_mon.valid && i_cfg_mon.ready) track_sectors = i_cfg_mon.track_sectors;
            if (i_in_mon.valid && i_in_mon.ready)
                take_block(i_in_mon.sector_addr, i_in_mon.sector_count);
        end
        o_fail_count <= fails;
        o_pending    <= expected_records.size();
    end

endmodule

// ----- tb/sv/sector_run_extent_encoder_core_tb.sv -----
`timescale 1ns / 100ps

module sector_run_extent_encoder_core_tb;
    localparam int ADDR_W  = srx_pkg::ADDR_W;
    localparam int COUNT_W = srx_pkg::COUNT_W;
    localparam int TRACK_W = srx_pkg::TRACK_W;

    localparam int MAX_RECORDS   = 64;
    localparam int CHUNK_LIMIT   = 768;
    localparam int SETTLE_CYCLES = 64;     // covers a flush that emits nothing
    localparam int STUCK_LIMIT   = 20000;  // cycles with no transfer at all
    localparam int SEGMENT_ITEMS = 16;

    logic               i_clk;
    logic               i_rst_n;
    int                 send_idle_pct;
    int                 recv_idle_pct;
    int                 fail_count;
    int                 pending_records;
    int                 stuck_cycles = 0;
    logic [ADDR_W-1:0]  next_contig;
    bit                 run_open;
    logic [TRACK_W-1:0] seg_track;

    srx_cfg_if cfg_bus();
    srx_in_if  blk_in();
    srx_out_if rec_out();

    sector_run_extent_encoder_core #(
        .MAX_RECORDS (MAX_RECORDS),
        .CHUNK_LIMIT (CHUNK_LIMIT)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_in    (blk_in),
        .o_out   (rec_out)
    );

    sector_run_extent_encoder_checker #(
        .MAX_RECORDS (MAX_RECORDS),
        .CHUNK_LIMIT (CHUNK_LIMIT)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_mon    (cfg_bus),
        .i_in_mon     (blk_in),
        .i_out_mon    (rec_out),
        .o_fail_count (fail_count),
        .o_pending    (pending_records)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // record sink stalls at random
    always @(posedge i_clk) begin
        rec_out.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog: too long without any transfer ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (blk_in.valid && blk_in.ready) || (rec_out.valid && rec_out.ready) ||
            (cfg_bus.valid && cfg_bus.ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // one block transfer; valid stays up afterwards so back-to-back blocks need no gap
    task automatic send_block(input logic [ADDR_W-1:0] a, input logic [COUNT_W-1:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            blk_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        blk_in.valid        <= 1'b1;
        blk_in.sector_addr  <= a;
        blk_in.sector_count <= c;
        do @(posedge i_clk); while (!blk_in.ready);
    endtask

    // hold off until every predicted record is out, then let the block settle
    task automatic drain_records();
        blk_in.valid <= 1'b0;
        do @(posedge i_clk); while (pending_records != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_track(input logic [TRACK_W-1:0] t);
        cfg_bus.valid         <= 1'b1;
        cfg_bus.track_sectors <= t;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
    endtask

    // mostly contiguous runs with random content, broken by flushes and jumps
    task automatic random_segment(input int n_items);
        logic [ADDR_W-1:0]  a;
        logic [COUNT_W-1:0] c;
        int                 pick;
        repeat (n_items) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                a = '0;
            end else if (pick < 72 && run_open) begin
                a = next_contig;
            end else begin
                pick = $urandom_range(99);
                if (pick < 60)      a = ADDR_W'($urandom_range(1, 5000));
                else if (pick < 85) a = {$urandom, $urandom};
                else                a = '1 - ADDR_W'($urandom_range(0, 300));
            end
            pick = $urandom_range(99);
            if (pick < 10)      c = '0;
            else if (pick < 20) c = 8'd128;
            else                c = COUNT_W'($urandom_range(1, 127));
            send_block(a, c);
            if (a == '0) begin
                run_open = 1'b0;
            end else if (!run_open || a != next_contig) begin
                run_open    = 1'b1;
                next_contig = a + ADDR_W'(c);
            end else begin
                next_contig = next_contig + ADDR_W'(c);
            end
        end
    endtask

    initial begin
        i_rst_n               = 1'b0;
        cfg_bus.valid         = 1'b0;
        cfg_bus.track_sectors = '0;
        blk_in.valid          = 1'b0;
        blk_in.sector_addr    = '0;
        blk_in.sector_count   = '0;
        rec_out.ready         = 1'b0;
        send_idle_pct         = 9;
        recv_idle_pct         = 58;
        run_open              = 1'b0;
        next_contig           = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // no geometry: whole run is one chunk
        write_track(6'd0);
        send_block('0, '0);                        // flush with nothing open
        send_block(64'd1, 8'd1);
        send_block(64'd2, 8'd5);
        send_block('0, '0);
        send_block(64'hFFFF_FFFF_FFFF_FFF0, 8'd128);  // eight address bytes, wraps inside
        send_block(64'd5, 8'd128);                 // jump flushes and restarts
        for (int k = 1; k < 6; k++) send_block(64'd5 + ADDR_W'(k) * 128, 8'd128);
        send_block('0, '0);                        // exactly the chunk limit
        send_block(64'd300, 8'd0);                 // zero-sector blocks
        send_block(64'd300, 8'd0);
        send_block(64'd300, 8'd3);
        send_block(64'd400, 8'd0);
        send_block('0, 8'd77);                     // run of length zero, no records
        for (int k = 0; k < 7; k++) send_block(64'd1000 + ADDR_W'(k) * 128, 8'd128);
        send_block('0, '0);                        // chunk over the limit

        drain_records();
        write_track(6'd63);
        send_block(64'd62, 8'd128);                // starts on last sector of a track
        send_block('0, '0);
        send_block(64'd70, 8'd100);                // mid-track start, normal first cut
        send_block('0, '0);

        drain_records();
        write_track(6'd4);
        send_block(64'hFFFF_FFFF_FFFF_FFFC, 8'd8); // second chunk starts at zero
        send_block('0, '0);

        drain_records();
        write_track(6'd1);
        send_block(64'd10, 8'd70);                 // too many records
        send_block(64'd500, 8'd2);                 // new run after the error
        send_block('0, '0);
        run_open = 1'b0;

        // random part: receiver-heavy idling, then sender-heavy, then none
        for (int seg = 0; seg < 6; seg++) begin
            if (seg == 2) begin
                send_idle_pct = 58;
                recv_idle_pct = 9;
            end else if (seg == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (seg)
                0:       seg_track = 6'd0;
                1:       seg_track = 6'd63;
                2:       seg_track = 6'd1;
                3:       seg_track = TRACK_W'($urandom_range(2, 62));
                4:       seg_track = 6'd32;
                default: seg_track = TRACK_W'($urandom_range(1, 63));
            endcase
            drain_records();
            write_track(seg_track);
            random_segment(SEGMENT_ITEMS);
        end

        drain_records();
        if (fail_count == 0 && pending_records == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
